/* sv/corruption_segment_comparator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the corruption segment comparator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CORRUPTION_SEGMENT_COMPARATOR_TOP_MACROS_SVH
`define CORRUPTION_SEGMENT_COMPARATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/csc_pkg.sv */
// ----------------------------------------------------------------------------
// Corruption segment comparator package
// Shared widths, codes, controller types and helper functions.
// ----------------------------------------------------------------------------
package csc_pkg;

   // Width of the byte and segment counters and of the wide result fields.
   localparam int CNT_W = 48;
   localparam int BYTE_W = 8;
   localparam int WIN_W = 8;
   localparam int RUN_W = 9;
   localparam int KIND_W = 2;
   localparam int PCT_W = 7;
   localparam int BND_W = 3;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);
   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   // Percentage divider: one quotient bit per step.
   localparam int PCT_STEPS = PCT_W;
   localparam int PCT_CNT_W = $clog2(PCT_STEPS + 1);
   localparam int DIV_W = CNT_W + 8;

   // Item opcodes.
   localparam logic OP_COMPARE = 1'b0;
   localparam logic OP_END = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REF_EXCESS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUS_EXCESS = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TOTALS = 2'd3;

   // Alignment classes.
   localparam logic [BND_W-1:0] BND_NONE = 3'd0;
   localparam logic [BND_W-1:0] BND_512 = 3'd1;
   localparam logic [BND_W-1:0] BND_1024 = 3'd2;
   localparam logic [BND_W-1:0] BND_2048 = 3'd3;
   localparam logic [BND_W-1:0] BND_4096 = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEG,
      ST_EXC,
      ST_TOT
   } state_type;

   typedef struct packed {
      logic accept_cmp;
      logic accept_end;
      logic div_start;
      logic load_seg;
      logic load_exc;
      logic load_tot;
      logic last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_diff;
      logic close;
      logic exc_nz;
      logic div_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   function automatic logic [BND_W-1:0] boundary_of(input logic [11:0] low);
      logic [BND_W-1:0] b;
      if (low[11:0] == 12'd0) begin
         b = BND_4096;
      end else if (low[10:0] == 11'd0) begin
         b = BND_2048;
      end else if (low[9:0] == 10'd0) begin
         b = BND_1024;
      end else if (low[8:0] == 9'd0) begin
         b = BND_512;
      end else begin
         b = BND_NONE;
      end
      return b;
   endfunction

endpackage

/* sv/csc_pct.sv */
// ----------------------------------------------------------------------------
// Zero percentage divider
// Computes floor(100 * part / whole) for part <= whole, one bit per cycle.
// ----------------------------------------------------------------------------
module csc_pct import csc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] part,
   input  logic [CNT_W-1:0] whole,
   output logic             done,
   output logic [PCT_W-1:0] quot
);

   logic [PCT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [PCT_W-1:0]     q_ff, q_in;
   logic                 zero_ff, zero_in;
   logic [DIV_W-1:0]     part_ext;

   assign part_ext = DIV_W'(part);

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      zero_in = zero_ff;
      if (start) begin
         // 100 * part as 64 + 32 + 4 times part.
         rem_in = (part_ext << 6) + (part_ext << 5) + (part_ext << 2);
         den_in = DIV_W'(whole) << (PCT_STEPS - 1);
         q_in = '0;
         zero_in = (whole == '0);
         cnt_in = PCT_CNT_W'(PCT_STEPS);
      end else if (cnt_ff != '0) begin
         if (rem_ff >= den_ff) begin
            rem_in = rem_ff - den_ff;
            q_in = {q_ff[PCT_W-2:0], 1'b1};
         end else begin
            q_in = {q_ff[PCT_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - PCT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      zero_ff <= zero_in;
   end

   assign done = (cnt_ff == '0);
   assign quot = zero_ff ? '0 : q_ff;

endmodule

/* sv/csc_dp.sv */
// ----------------------------------------------------------------------------
// Corruption segment comparator datapath
// Stream state, counters, window register, divider and the result register.
// ----------------------------------------------------------------------------
`include "corruption_segment_comparator_top_macros.svh"

module csc_dp import csc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_reference_byte,
   input  logic [BYTE_W-1:0] req_suspect_byte,
   input  logic [CNT_W-1:0]  req_excess_bytes,
   input  logic              req_longer_side,
   input  logic              csr_we,
   input  logic [WIN_W-1:0]  csr_window_length,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [CNT_W-1:0]  rsp_diff_number,
   output logic [CNT_W-1:0]  rsp_start_offset,
   output logic [CNT_W-1:0]  rsp_length,
   output logic [CNT_W-1:0]  rsp_zero_count,
   output logic [PCT_W-1:0]  rsp_zero_percent,
   output logic [BND_W-1:0]  rsp_boundary,
   output logic [CNT_W-1:0]  rsp_total_differences,
   output logic [CNT_W-1:0]  rsp_total_diff_bytes,
   output logic              rsp_last
);

   logic [WIN_W-1:0] wl_ff, wl_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             in_diff_ff, in_diff_in;
   logic [CNT_W-1:0] seg_start_ff, seg_start_in;
   logic [CNT_W-1:0] seg_len_ff, seg_len_in;
   logic [CNT_W-1:0] seg_zeros_ff, seg_zeros_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] diff_cnt_ff, diff_cnt_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] excess_ff, excess_in;
   logic             side_ff, side_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [CNT_W-1:0]  out_num_ff, out_num_in;
   logic [CNT_W-1:0]  out_start_ff, out_start_in;
   logic [CNT_W-1:0]  out_len_ff, out_len_in;
   logic [CNT_W-1:0]  out_zeros_ff, out_zeros_in;
   logic [PCT_W-1:0]  out_pct_ff, out_pct_in;
   logic [BND_W-1:0]  out_bnd_ff, out_bnd_in;
   logic [CNT_W-1:0]  out_tdiff_ff, out_tdiff_in;
   logic [CNT_W-1:0]  out_tbytes_ff, out_tbytes_in;
   logic              out_last_ff, out_last_in;

   logic             mismatch;
   logic [RUN_W-1:0] run_next;
   logic             load_any;
   logic             pct_done;
   logic [PCT_W-1:0] pct_q;

   csc_pct u_pct (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .part  (seg_zeros_ff),
      .whole (seg_len_ff),
      .done  (pct_done),
      .quot  (pct_q)
   );

   assign mismatch = (req_reference_byte != req_suspect_byte);
   assign run_next = (run_ff == RUN_MAX) ? run_ff : run_ff + RUN_W'(1);
   assign load_any = cmd.load_seg | cmd.load_exc | cmd.load_tot;

   always_comb begin
      status.in_diff = in_diff_ff;
      // A matching byte closes the segment after window_length + 1 matches in a row.
      status.close = (req_op == OP_COMPARE) && in_diff_ff && !mismatch &&
                     (run_next >= ({1'b0, wl_ff} + RUN_W'(1)));
      status.exc_nz = (excess_ff != '0);
      status.div_done = pct_done;
      status.out_free = !out_valid_ff || !rsp_stall;
   end

   // Stream state.
   always_comb begin
      wl_in = wl_ff;
      pos_in = pos_ff;
      in_diff_in = in_diff_ff;
      seg_start_in = seg_start_ff;
      seg_len_in = seg_len_ff;
      seg_zeros_in = seg_zeros_ff;
      run_in = run_ff;
      diff_cnt_in = diff_cnt_ff;
      total_in = total_ff;
      excess_in = excess_ff;
      side_in = side_ff;

      if (csr_we) begin
         wl_in = csr_window_length;
      end

      if (cmd.accept_cmp) begin
         if (mismatch) begin
            if (!in_diff_ff) begin
               in_diff_in = 1'b1;
               seg_start_in = pos_ff;
               seg_len_in = CNT_W'(1);
               seg_zeros_in = CNT_W'(req_suspect_byte == '0);
               diff_cnt_in = sat_inc(diff_cnt_ff);
            end else begin
               seg_len_in = sat_inc(seg_len_ff);
               if (req_suspect_byte == '0) begin
                  seg_zeros_in = sat_inc(seg_zeros_ff);
               end
            end
            total_in = sat_inc(total_ff);
            run_in = '0;
         end else if (in_diff_ff) begin
            run_in = run_next;
         end
         pos_in = sat_inc(pos_ff);
      end

      if (cmd.accept_end) begin
         excess_in = req_excess_bytes;
         side_in = req_longer_side;
      end

      // The segment stays intact until it has been reported.
      if (cmd.load_seg) begin
         in_diff_in = 1'b0;
         seg_start_in = '0;
         seg_len_in = '0;
         seg_zeros_in = '0;
         run_in = '0;
      end

      if (cmd.load_exc) begin
         diff_cnt_in = sat_inc(diff_cnt_ff);
         total_in = sat_add(total_ff, excess_ff);
      end

      if (cmd.load_tot) begin
         pos_in = '0;
      end
   end

   // Result register.
   always_comb begin
      out_kind_in = out_kind_ff;
      out_num_in = out_num_ff;
      out_start_in = out_start_ff;
      out_len_in = out_len_ff;
      out_zeros_in = out_zeros_ff;
      out_pct_in = out_pct_ff;
      out_bnd_in = out_bnd_ff;
      out_tdiff_in = out_tdiff_ff;
      out_tbytes_in = out_tbytes_ff;
      out_last_in = out_last_ff;

      if (load_any) begin
         out_kind_in = KIND_SEGMENT;
         out_num_in = '0;
         out_start_in = '0;
         out_len_in = '0;
         out_zeros_in = '0;
         out_pct_in = '0;
         out_bnd_in = BND_NONE;
         out_tdiff_in = '0;
         out_tbytes_in = '0;
         out_last_in = cmd.last;
      end

      if (cmd.load_seg) begin
         out_num_in = diff_cnt_ff;
         out_start_in = seg_start_ff;
         out_len_in = seg_len_ff;
         out_zeros_in = seg_zeros_ff;
         out_pct_in = pct_q;
         out_bnd_in = boundary_of(seg_start_ff[11:0]);
      end else if (cmd.load_exc) begin
         out_kind_in = side_ff ? KIND_SUS_EXCESS : KIND_REF_EXCESS;
         out_num_in = sat_inc(diff_cnt_ff);
         out_start_in = pos_ff;
         out_len_in = excess_ff;
      end else if (cmd.load_tot) begin
         out_kind_in = KIND_TOTALS;
         out_tdiff_in = diff_cnt_ff;
         out_tbytes_in = total_ff;
      end

      if (load_any) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WINDOW_RESET;
         pos_ff <= '0;
         in_diff_ff <= 1'b0;
         seg_start_ff <= '0;
         seg_len_ff <= '0;
         seg_zeros_ff <= '0;
         run_ff <= '0;
         diff_cnt_ff <= '0;
         total_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wl_ff <= wl_in;
         pos_ff <= pos_in;
         in_diff_ff <= in_diff_in;
         seg_start_ff <= seg_start_in;
         seg_len_ff <= seg_len_in;
         seg_zeros_ff <= seg_zeros_in;
         run_ff <= run_in;
         diff_cnt_ff <= diff_cnt_in;
         total_ff <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      excess_ff <= excess_in;
      side_ff <= side_in;
      out_kind_ff <= out_kind_in;
      out_num_ff <= out_num_in;
      out_start_ff <= out_start_in;
      out_len_ff <= out_len_in;
      out_zeros_ff <= out_zeros_in;
      out_pct_ff <= out_pct_in;
      out_bnd_ff <= out_bnd_in;
      out_tdiff_ff <= out_tdiff_in;
      out_tbytes_ff <= out_tbytes_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_diff_number = out_num_ff;
   assign rsp_start_offset = out_start_ff;
   assign rsp_length = out_len_ff;
   assign rsp_zero_count = out_zeros_ff;
   assign rsp_zero_percent = out_pct_ff;
   assign rsp_boundary = out_bnd_ff;
   assign rsp_total_differences = out_tdiff_ff;
   assign rsp_total_diff_bytes = out_tbytes_ff;
   assign rsp_last = out_last_ff;

   `CSC_ASSERT_IMP(a_zeros_within_len, clock, reset, 1'b1, seg_zeros_ff <= seg_len_ff, "segment zero count exceeds its length")
   `CSC_ASSERT_IMP(a_closed_is_empty, clock, reset, !in_diff_ff, seg_len_ff == '0 && run_ff == '0, "closed segment holds stale state")
   `CSC_ASSERT_IMP(a_seg_report_open, clock, reset, cmd.load_seg, in_diff_ff && pct_done, "segment reported while none is open")

endmodule

/* sv/csc_ctrl.sv */
// ----------------------------------------------------------------------------
// Corruption segment comparator controller
// Sequences item acceptance, the percentage divide and result loads.
// ----------------------------------------------------------------------------
`include "corruption_segment_comparator_top_macros.svh"

module csc_ctrl import csc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_op,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      end_ff, end_in;
   logic      accept;
   logic [2:0] loads;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign end_in = accept ? (req_op == OP_END) : end_ff;
   assign loads = {cmd.load_seg, cmd.load_exc, cmd.load_tot};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_END) begin
                  state_in = status.in_diff ? ST_DIV : ST_EXC;
               end else if (status.close) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (status.out_free) begin
               state_in = end_ff ? ST_EXC : ST_IDLE;
            end
         end
         ST_EXC: begin
            if (!status.exc_nz || status.out_free) begin
               state_in = ST_TOT;
            end
         end
         ST_TOT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept_cmp = accept && (req_op == OP_COMPARE);
            cmd.accept_end = accept && (req_op == OP_END);
            cmd.div_start = (cmd.accept_cmp && status.close) ||
                            (cmd.accept_end && status.in_diff);
         end
         ST_SEG: begin
            cmd.load_seg = status.out_free;
            cmd.last = !end_ff;
         end
         ST_EXC: begin
            cmd.load_exc = status.out_free && status.exc_nz;
         end
         ST_TOT: begin
            cmd.load_tot = status.out_free;
            cmd.last = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff <= end_in;
      end
   end

   `CSC_ASSERT_IMP(a_one_load, clock, reset, 1'b1, $onehot0(loads), "more than one result loaded at once")
   `CSC_ASSERT_NXT(a_div_follows_start, clock, reset, cmd.div_start, state_ff == ST_DIV, "divide started without entering the divide state")
   `CSC_ASSERT_IMP(a_seg_after_div, clock, reset, state_ff == ST_SEG, status.div_done, "segment result pending while the divider runs")

endmodule

/* sv/corruption_segment_comparator_top.sv */
// ----------------------------------------------------------------------------
// Corruption segment comparator
// Finds differing segments between a reference and a suspect byte stream.
// ----------------------------------------------------------------------------
// A compare item that does not close a segment leaves the controller idle, so
// byte pairs stream at one per clock. A compare item that closes a segment
// stalls the input after it is accepted: the zero percentage comes from a
// restoring divider that produces one of its seven quotient bits per cycle,
// the controller then sees the divider finish, and the result register loads.
// An end item stalls the input through the excess step, which loads an excess
// result only when the excess is nonzero, and through the totals result, after
// it first flushes any open segment through the divider. Results sit in an
// output register; a result load waits while that register holds a stalled
// result, and that wait lengthens the stall. Counters saturate at all ones.
// csr_ready is always high; write the window only while the block is idle.
// ----------------------------------------------------------------------------
module corruption_segment_comparator_top import csc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_reference_byte,
   input  logic [BYTE_W-1:0] req_suspect_byte,
   input  logic [CNT_W-1:0]  req_excess_bytes,
   input  logic              req_longer_side,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [CNT_W-1:0]  rsp_diff_number,
   output logic [CNT_W-1:0]  rsp_start_offset,
   output logic [CNT_W-1:0]  rsp_length,
   output logic [CNT_W-1:0]  rsp_zero_count,
   output logic [PCT_W-1:0]  rsp_zero_percent,
   output logic [BND_W-1:0]  rsp_boundary,
   output logic [CNT_W-1:0]  rsp_total_differences,
   output logic [CNT_W-1:0]  rsp_total_diff_bytes,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WIN_W-1:0]  csr_window_length
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   csc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   csc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_op                (req_op),
      .req_reference_byte    (req_reference_byte),
      .req_suspect_byte      (req_suspect_byte),
      .req_excess_bytes      (req_excess_bytes),
      .req_longer_side       (req_longer_side),
      .csr_we                (csr_valid && csr_ready),
      .csr_window_length     (csr_window_length),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_kind              (rsp_kind),
      .rsp_diff_number       (rsp_diff_number),
      .rsp_start_offset      (rsp_start_offset),
      .rsp_length            (rsp_length),
      .rsp_zero_count        (rsp_zero_count),
      .rsp_zero_percent      (rsp_zero_percent),
      .rsp_boundary          (rsp_boundary),
      .rsp_total_differences (rsp_total_differences),
      .rsp_total_diff_bytes  (rsp_total_diff_bytes),
      .rsp_last              (rsp_last)
   );

endmodule
